// File: rtl/safk_pkg.sv
// Shared types, widths and constants of the serial arm forward kinematics unit.
// No dependencies; every other file in rtl imports this package.
package safk_pkg;

    // Angle and position formats
    localparam int ANGLE_IN_W   = 20;
    localparam int DIST_W       = 21;
    localparam int OUT_W        = 24;
    localparam int ANG_W        = 35;   // Q.30 radians, room for +-16 rad
    localparam int TRIG_W       = 33;   // Q.30 sine and cosine
    localparam int POS_W        = 35;   // Q.28 metres
    localparam int POS_FRAC     = 28;
    localparam int ANG_FRAC     = 30;
    localparam int NUM_JOINTS   = 6;    // joint seven turns about the tool axis only
    localparam int ATAN_ENTRIES = 24;

    // Parameter defaults
    localparam int TRIG_ITERATIONS_DEF    = 16;
    localparam int POSITION_FRAC_BITS_DEF = 20;

    localparam logic signed [ANG_W-1:0]  PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0]  TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30    = 33'sd652032874;

    localparam logic signed [OUT_W:0] OUT_MAX = 25'sd8388607;
    localparam logic signed [OUT_W:0] OUT_MIN = -25'sd8388608;

    // Configuration register indexes
    localparam logic [1:0] REG_BASE_HEIGHT = 2'd0;
    localparam logic [1:0] REG_UPPER_ARM   = 2'd1;
    localparam logic [1:0] REG_FOREARM     = 2'd2;
    localparam logic [1:0] REG_FLANGE      = 2'd3;

    localparam logic [DIST_W-1:0] BASE_HEIGHT_RST = 21'd356516;
    localparam logic [DIST_W-1:0] UPPER_ARM_RST   = 21'd419430;
    localparam logic [DIST_W-1:0] FOREARM_RST     = 21'd419430;
    localparam logic [DIST_W-1:0] FLANGE_RST      = 21'd132121;

    // One CORDIC lane between cells
    typedef struct packed {
        logic                     neg;
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
    } cordic_t;

    // Finished sine and cosine of one joint, sign fold not yet applied
    typedef struct packed {
        logic                     neg;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    // Partial position handed along the joint chain
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } pos_t;

    // Arctangent of 2^-i in Q.30, truncated toward zero
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        case (i)
            0:       r = 32'h3243F6A8;
            1:       r = 32'h1DAC6705;
            2:       r = 32'h0FADBAFC;
            3:       r = 32'h07F56EA6;
            4:       r = 32'h03FEAB76;
            5:       r = 32'h01FFD55B;
            6:       r = 32'h00FFFAAA;
            7:       r = 32'h007FFF55;
            8:       r = 32'h003FFFEA;
            9:       r = 32'h001FFFFD;
            10:      r = 32'h000FFFFF;
            11:      r = 32'h0007FFFF;
            12:      r = 32'h0003FFFF;
            13:      r = 32'h0001FFFF;
            14:      r = 32'h0000FFFF;
            15:      r = 32'h00007FFF;
            16:      r = 32'h00003FFF;
            17:      r = 32'h00001FFF;
            18:      r = 32'h00000FFF;
            19:      r = 32'h000007FF;
            20:      r = 32'h000003FF;
            21:      r = 32'h000001FF;
            22:      r = 32'h000000FF;
            23:      r = 32'h0000007F;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/serial_arm_forward_kinematics_unit.sv
// Top level of the serial arm forward kinematics unit: CORDIC lanes, delay
// alignment, joint chain and output rounding. Depends on safk_pkg and all rtl cells.
//
// Usage:
//   Raise start with seven joint angles (signed Q3.16 radians) on the
//   joint_angle ports; the beat is taken at that edge while busy is low.
//   busy never rises, so a new pose can be given in every cycle.
//   done pulses for one cycle with pos_x, pos_y, pos_z (signed, saturated,
//   POSITION_FRAC_BITS fraction bits) once the start beat has passed the
//   angle stage, the CORDIC cell row, the joint cells and the output stage.
//   Throughput is one pose per cycle.
//   Joint seven turns about the tool axis and does not move the position.
//   The link offsets are written through cfg_we, cfg_index and cfg_wdata
//   while no pose is in flight; a write takes effect at once.
//   Reset clears the in-flight marks and restores the default offsets.
//   There is no back-pressure: each result is shown for one cycle only.
module serial_arm_forward_kinematics_unit
    import safk_pkg::*;
#(
    parameter int TRIG_ITERATIONS    = TRIG_ITERATIONS_DEF,
    parameter int POSITION_FRAC_BITS = POSITION_FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [DIST_W-1:0]            cfg_wdata,
    input  logic signed [ANGLE_IN_W-1:0] joint_angle_1,
    input  logic signed [ANGLE_IN_W-1:0] joint_angle_2,
    input  logic signed [ANGLE_IN_W-1:0] joint_angle_3,
    input  logic signed [ANGLE_IN_W-1:0] joint_angle_4,
    input  logic signed [ANGLE_IN_W-1:0] joint_angle_5,
    input  logic signed [ANGLE_IN_W-1:0] joint_angle_6,
    input  logic signed [ANGLE_IN_W-1:0] joint_angle_7,
    output logic                         done,
    output logic signed [OUT_W-1:0]      pos_x,
    output logic signed [OUT_W-1:0]      pos_y,
    output logic signed [OUT_W-1:0]      pos_z
);

    localparam int LAT     = TRIG_ITERATIONS + 2 * NUM_JOINTS + 2;
    localparam int RND_SH  = POS_FRAC - POSITION_FRAC_BITS;
    localparam logic signed [POS_W:0] RND_ADD =
        (RND_SH > 0) ? (POS_W+1)'(1) << (RND_SH - 1) : '0;

    logic [DIST_W-1:0] base_height_reg;
    logic [DIST_W-1:0] upper_arm_reg;
    logic [DIST_W-1:0] forearm_reg;
    logic [DIST_W-1:0] flange_reg;
    logic [LAT-1:0]    vld_reg;
    logic [LAT-1:0]    vld_next;

    logic signed [ANGLE_IN_W-1:0] angles [NUM_JOINTS];
    cordic_t lanes [NUM_JOINTS][TRIG_ITERATIONS+1];
    trig_t   trig_al [NUM_JOINTS];
    pos_t    chain [NUM_JOINTS+1];
    logic [DIST_W-1:0] offs [NUM_JOINTS];

    logic signed [OUT_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg <= BASE_HEIGHT_RST;
            upper_arm_reg   <= UPPER_ARM_RST;
            forearm_reg     <= FOREARM_RST;
            flange_reg      <= FLANGE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_HEIGHT: base_height_reg <= cfg_wdata;
                REG_UPPER_ARM:   upper_arm_reg   <= cfg_wdata;
                REG_FOREARM:     forearm_reg     <= cfg_wdata;
                REG_FLANGE:      flange_reg      <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Advance the in-flight marks alongside the data
    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign busy = 1'b0;

    // Joint seven only spins the tool, so its angle is not routed on
    assign angles[0] = joint_angle_1;
    assign angles[1] = joint_angle_2;
    assign angles[2] = joint_angle_3;
    assign angles[3] = joint_angle_4;
    assign angles[4] = joint_angle_5;
    assign angles[5] = joint_angle_6 | (joint_angle_7 & '0);

    assign offs[0] = base_height_reg;
    assign offs[1] = '0;
    assign offs[2] = upper_arm_reg;
    assign offs[3] = '0;
    assign offs[4] = forearm_reg;
    assign offs[5] = '0;

    // CORDIC lanes and their alignment delays
    genvar j, k;
    generate
        for (j = 0; j < NUM_JOINTS; j++)
        begin : g_lane
            localparam int DLY = 2 * (NUM_JOINTS - 1 - j);
            trig_t t0;

            safk_angle_prep u_prep (
                .clk   (clk),
                .angle (angles[j]),
                .lane  (lanes[j][0])
            );

            for (k = 0; k < TRIG_ITERATIONS; k++)
            begin : g_cell
                safk_cordic_cell #(.STAGE(k)) u_cell (
                    .clk (clk),
                    .d   (lanes[j][k]),
                    .q   (lanes[j][k+1])
                );
            end

            assign t0.neg   = lanes[j][TRIG_ITERATIONS].neg;
            assign t0.cos_v = lanes[j][TRIG_ITERATIONS].x;
            assign t0.sin_v = lanes[j][TRIG_ITERATIONS].y;

            if (DLY == 0)
            begin : g_nodly
                assign trig_al[j] = t0;
            end
            else
            begin : g_dly
                trig_t dly_reg [DLY];
                always_ff @(posedge clk)
                begin
                    dly_reg[0] <= t0;
                    for (int m = 1; m < DLY; m++)
                        dly_reg[m] <= dly_reg[m-1];
                end
                assign trig_al[j] = dly_reg[DLY-1];
            end
        end

        // Joint chain, last link first
        assign chain[0].x = '0;
        assign chain[0].y = '0;
        assign chain[0].z = POS_W'({flange_reg, 8'b0});

        for (j = 0; j < NUM_JOINTS; j++)
        begin : g_joint
            localparam int JI = NUM_JOINTS - 1 - j;
            safk_joint_cell #(.ALPHA_NEG((JI % 2) == 0)) u_joint (
                .clk   (clk),
                .trig  (trig_al[JI]),
                .p_in  (chain[j]),
                .offs  (offs[JI]),
                .p_out (chain[j+1])
            );
        end
    endgenerate

    // Round half up to the output format and saturate
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [POS_W-1:0] v);
        logic signed [POS_W:0] r;
        logic signed [POS_W:0] sh;
        logic signed [OUT_W-1:0] o;
        r  = (POS_W+1)'(v) + RND_ADD;
        sh = r >>> RND_SH;
        if (sh > (POS_W+1)'(OUT_MAX))
            o = OUT_W'(OUT_MAX);
        else if (sh < (POS_W+1)'(OUT_MIN))
            o = OUT_W'(OUT_MIN);
        else
            o = OUT_W'(sh);
        return o;
    endfunction

    always_ff @(posedge clk)
    begin
        pos_x_reg <= round_sat(chain[NUM_JOINTS].x);
        pos_y_reg <= round_sat(chain[NUM_JOINTS].y);
        pos_z_reg <= round_sat(chain[NUM_JOINTS].z);
    end

    assign done  = vld_reg[LAT-1];
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;

    // A result beat only follows an accepted start beat
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("done without a start beat LAT cycles earlier");

    // A base height write lands in the register on the next edge
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_BASE_HEIGHT) |=> base_height_reg == $past(cfg_wdata))
        else $error("base height write lost");

endmodule

// File: rtl/safk_angle_prep.sv
// Angle range reduction and quadrant fold ahead of one CORDIC lane.
// Depends on safk_pkg.
module safk_angle_prep
    import safk_pkg::*;
(
    input  logic                         clk,
    input  logic signed [ANGLE_IN_W-1:0] angle,
    output cordic_t                      lane
);

    logic signed [ANG_W-1:0] wide;
    logic signed [ANG_W-1:0] turn;
    cordic_t                 lane_next;
    cordic_t                 lane_reg;

    // Widen to Q.30, drop a whole turn, fold into the right half-plane
    always_comb
    begin
        wide = {{(ANG_W-ANGLE_IN_W-14){angle[ANGLE_IN_W-1]}}, angle, 14'b0};
        if (wide > PI_Q30)
            turn = wide - TWO_PI_Q30;
        else if (wide < -PI_Q30)
            turn = wide + TWO_PI_Q30;
        else
            turn = wide;
        lane_next.x = GAIN_Q30;
        lane_next.y = '0;
        if (turn > HALF_PI_Q30)
        begin
            lane_next.z   = turn - PI_Q30;
            lane_next.neg = 1'b1;
        end
        else if (turn < -HALF_PI_Q30)
        begin
            lane_next.z   = turn + PI_Q30;
            lane_next.neg = 1'b1;
        end
        else
        begin
            lane_next.z   = turn;
            lane_next.neg = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane = lane_reg;

endmodule

// File: rtl/safk_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation, registered.
// Depends on safk_pkg.
module safk_cordic_cell
    import safk_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic    clk,
    input  cordic_t d,
    output cordic_t q
);

    localparam logic signed [ANG_W-1:0] ATAN_C = ANG_W'(atan_q30(STAGE));

    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    cordic_t                  q_next;
    cordic_t                  q_reg;

    // Rotate toward zero residual angle
    always_comb
    begin
        dx         = d.y >>> STAGE;
        dy         = d.x >>> STAGE;
        q_next.neg = d.neg;
        if (!d.z[ANG_W-1])
        begin
            q_next.x = d.x - dx;
            q_next.y = d.y + dy;
            q_next.z = d.z - ATAN_C;
        end
        else
        begin
            q_next.x = d.x + dx;
            q_next.y = d.y - dy;
            q_next.z = d.z + ATAN_C;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// File: rtl/safk_joint_cell.sv
// One link of the position chain: twist, rotate by the joint angle, add offset.
// Two register stages: products, then sum and rounding. Depends on safk_pkg.
module safk_joint_cell
    import safk_pkg::*;
#(
    parameter bit ALPHA_NEG = 1'b1
)
(
    input  logic              clk,
    input  trig_t             trig,
    input  pos_t              p_in,
    input  logic [DIST_W-1:0] offs,
    output pos_t              p_out
);

    localparam int PROD_W = TRIG_W + POS_W;

    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
    logic signed [POS_W-1:0]  ty;
    logic signed [POS_W-1:0]  tz;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [POS_W-1:0]  z_reg;
    logic signed [PROD_W:0]   sum_x;
    logic signed [PROD_W:0]   sum_y;
    pos_t                     out_next;
    pos_t                     out_reg;

    // Apply the fold sign and the link twist
    always_comb
    begin
        c = trig.neg ? -trig.cos_v : trig.cos_v;
        s = trig.neg ? -trig.sin_v : trig.sin_v;
        if (ALPHA_NEG)
        begin
            ty = p_in.z;
            tz = -p_in.y;
        end
        else
        begin
            ty = -p_in.z;
            tz = p_in.y;
        end
    end

    // Hold the four rotation products
    always_ff @(posedge clk)
    begin
        p1_reg <= c * p_in.x;
        p2_reg <= s * ty;
        p3_reg <= s * p_in.x;
        p4_reg <= c * ty;
        z_reg  <= tz + POS_W'({offs, 8'b0});
    end

    // Sum and round half up back to Q.28
    always_comb
    begin
        sum_x = (PROD_W+1)'(p1_reg) - (PROD_W+1)'(p2_reg) + (PROD_W+1)'(1) * (2 ** 29);
        sum_y = (PROD_W+1)'(p3_reg) + (PROD_W+1)'(p4_reg) + (PROD_W+1)'(1) * (2 ** 29);
        out_next.x = POS_W'(sum_x >>> ANG_FRAC);
        out_next.y = POS_W'(sum_y >>> ANG_FRAC);
        out_next.z = z_reg;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign p_out = out_reg;

endmodule

// File: bench/serial_arm_forward_kinematics_unit_tb.sv
// Self-checking bench for the serial arm forward kinematics unit: drives joint poses,
// predicts the end-effector position in fixed point and compares every result beat.
// Depends on safk_pkg and the rtl top level serial_arm_forward_kinematics_unit.
`timescale 1ns / 100ps

module serial_arm_forward_kinematics_unit_tb;
    import safk_pkg::*;

    localparam int CHAIN_LATENCY = 30;
    localparam int DRAIN_CYCLES  = CHAIN_LATENCY + 10;
    localparam int CORDIC_STEPS  = 16;
    localparam int ANGLE_HALF_PI = 102944;    // pi/2 in Q3.16
    localparam int ANGLE_PI      = 205887;    // pi in Q3.16

    typedef logic signed [ANGLE_IN_W-1:0] angle_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } tool_pos_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [DIST_W-1:0] cfg_wdata;
    angle_t joint_angle_1, joint_angle_2, joint_angle_3, joint_angle_4;
    angle_t joint_angle_5, joint_angle_6, joint_angle_7;
    logic done;
    logic signed [OUT_W-1:0] pos_x, pos_y, pos_z;

    // Bench copy of the link offsets
    logic [DIST_W-1:0] link_offset [4];

    tool_pos_t expected_poses [$];
    int mismatches;
    int results_seen;
    int sender_idle_pct;
    logic busy_seen;

    const longint ATAN_TABLE [CORDIC_STEPS] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    serial_arm_forward_kinematics_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .joint_angle_1(joint_angle_1), .joint_angle_2(joint_angle_2),
        .joint_angle_3(joint_angle_3), .joint_angle_4(joint_angle_4),
        .joint_angle_5(joint_angle_5), .joint_angle_6(joint_angle_6),
        .joint_angle_7(joint_angle_7),
        .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sine and cosine in Q.30 after turn reduction and the fold by pi
    task automatic joint_trig(input angle_t ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) <<< 14;
        x = longint'(GAIN_Q30);
        y = 0;
        flip = 1'b0;
        while (z > longint'(PI_Q30))
            z = z - longint'(TWO_PI_Q30);
        while (z < -longint'(PI_Q30))
            z = z + longint'(TWO_PI_Q30);
        if (z > longint'(HALF_PI_Q30))
        begin
            z = z - longint'(PI_Q30);
            flip = 1'b1;
        end
        else if (z < -longint'(HALF_PI_Q30))
        begin
            z = z + longint'(PI_Q30);
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TABLE[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TABLE[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Round Q.28 to the output format and clamp to 24 bits
    function automatic logic signed [OUT_W-1:0] clamp_position(input longint v);
        longint r;
        r = (v + 128) >>> 8;
        if (r > 64'sd8388607)
            r = 64'sd8388607;
        if (r < -64'sd8388608)
            r = -64'sd8388608;
        return r[OUT_W-1:0];
    endfunction

    // Walk the joint chain from the flange back to the base
    task automatic predict_tool_pos(input angle_t ang [7], output tool_pos_t p);
        longint x, y, z, tx, ty, tz, s, c, d;
        x = 0;
        y = 0;
        z = longint'(link_offset[REG_FLANGE]) <<< 8;
        for (int j = 5; j >= 0; j--)
        begin
            tx = x;
            if ((j % 2) == 0)
            begin
                ty = z;
                tz = -y;
            end
            else
            begin
                ty = -z;
                tz = y;
            end
            joint_trig(ang[j], s, c);
            x = (c * tx - s * ty + 64'sd536870912) >>> 30;
            y = (s * tx + c * ty + 64'sd536870912) >>> 30;
            case (j)
                0:       d = longint'(link_offset[REG_BASE_HEIGHT]);
                2:       d = longint'(link_offset[REG_UPPER_ARM]);
                4:       d = longint'(link_offset[REG_FOREARM]);
                default: d = 0;
            endcase
            z = tz + (d <<< 8);
        end
        p.x = clamp_position(x);
        p.y = clamp_position(y);
        p.z = clamp_position(z);
    endtask

    // Hold the busy level seen just before each rising edge
    always @(negedge clk)
        busy_seen <= busy;

    // Compare each result beat with the oldest expected pose
    always @(posedge clk)
    begin
        tool_pos_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat x=%0d y=%0d z=%0d", pos_x, pos_y, pos_z);
            end
            else
            begin
                want = expected_poses.pop_front();
                if (want.x !== pos_x || want.y !== pos_y || want.z !== pos_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pose mismatch: want x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                 want.x, want.y, want.z, pos_x, pos_y, pos_z);
                end
            end
        end
    end

    // Present one pose and hold it until taken; start stays high for a following beat
    task automatic send_pose(input angle_t ang [7]);
        tool_pos_t p;
        int gap;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        joint_angle_1 <= ang[0];
        joint_angle_2 <= ang[1];
        joint_angle_3 <= ang[2];
        joint_angle_4 <= ang[3];
        joint_angle_5 <= ang[4];
        joint_angle_6 <= ang[5];
        joint_angle_7 <= ang[6];
        do
            @(posedge clk);
        while (busy_seen);
        predict_tool_pos(ang, p);
        expected_poses.insert(expected_poses.size(), p);
    endtask

    // Drop start and let the pipeline drain completely
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (expected_poses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_offsets(input logic [DIST_W-1:0] d0, input logic [DIST_W-1:0] d1,
                                 input logic [DIST_W-1:0] d2, input logic [DIST_W-1:0] d3);
        logic [DIST_W-1:0] vals [4];
        vals = '{d0, d1, d2, d3};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            link_offset[i] = vals[i];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic angle_t random_angle();
        if ($urandom_range(2) == 0)
            return angle_t'($urandom);
        return angle_t'($signed($urandom_range(2 * ANGLE_PI)) - ANGLE_PI);
    endfunction

    // Extremes, quadrant edges, whole-turn reduction and a stretched arm
    task automatic test_directed_poses();
        angle_t ang [7];
        int picks [10];
        picks = '{0, -524288, 524287, ANGLE_HALF_PI, -ANGLE_HALF_PI, ANGLE_HALF_PI + 1,
                  ANGLE_PI, -ANGLE_PI - 1, 3 * ANGLE_PI, -1};
        for (int k = 0; k < 10; k++)
        begin
            foreach (ang[j])
                ang[j] = angle_t'(picks[k]);
            send_pose(ang);
        end
        for (int j = 0; j < 7; j++)
        begin
            foreach (ang[m])
                ang[m] = 0;
            ang[j] = (j % 2) ? angle_t'(ANGLE_HALF_PI) : angle_t'(-524288);
            send_pose(ang);
        end
        drain_pipeline();
    endtask

    task automatic test_random_poses(input int count);
        angle_t ang [7];
        for (int n = 0; n < count; n++)
        begin
            foreach (ang[j])
                ang[j] = random_angle();
            send_pose(ang);
        end
        drain_pipeline();
    endtask

    task automatic test_offset_extremes();
        angle_t ang [7];
        write_offsets('1, '1, '1, '1);
        foreach (ang[j])
            ang[j] = 0;
        send_pose(ang);
        ang[1] = angle_t'(ANGLE_PI);
        send_pose(ang);
        test_random_poses(150);
        write_offsets('0, '0, '0, '0);
        test_random_poses(60);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        {joint_angle_1, joint_angle_2, joint_angle_3, joint_angle_4} = '0;
        {joint_angle_5, joint_angle_6, joint_angle_7} = '0;
        link_offset = '{BASE_HEIGHT_RST, UPPER_ARM_RST, FOREARM_RST, FLANGE_RST};
        mismatches = 0;
        results_seen = 0;
        sender_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_poses();
        test_random_poses(300);
        sender_idle_pct = 51;
        test_offset_extremes();
        write_offsets(21'($urandom), 21'($urandom), 21'($urandom), 21'($urandom));
        test_random_poses(300);
        sender_idle_pct = 29;
        write_offsets(BASE_HEIGHT_RST, UPPER_ARM_RST, FOREARM_RST, FLANGE_RST);
        test_random_poses(350);

        $display("Covered %0d poses over default, full-scale, zero and random link offsets,",
                 results_seen);
        $display("with back-to-back and gapped start beats; %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/safk_pkg.sv
rtl/safk_angle_prep.sv
rtl/safk_cordic_cell.sv
rtl/safk_joint_cell.sv
rtl/serial_arm_forward_kinematics_unit.sv
bench/serial_arm_forward_kinematics_unit_tb.sv
